[sv/tcpc_pkg.sv]
package tcpc_pkg;

  // frame store geometry
  localparam int unsigned MaxColumns = 128;
  localparam int unsigned MaxRows    = 64;
  localparam int unsigned CellCount  = MaxColumns * MaxRows;
  localparam int unsigned CellIdxW   = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int unsigned ColW       = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int unsigned RowW       = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned WidthW     = $clog2(MaxColumns + 1);
  localparam int unsigned HeightW    = $clog2(MaxRows + 1);

  // register and field widths
  localparam int unsigned ScrWidthW  = 8;
  localparam int unsigned ScrHeightW = 7;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CellIndexW = 13;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned AttrW      = 16;
  localparam int unsigned OrderW     = 16;
  localparam int unsigned CharW      = 8;
  localparam int unsigned StatusW    = 3;

  localparam logic [ScrWidthW-1:0]  ResetWidth  = 8'd80;
  localparam logic [ScrHeightW-1:0] ResetHeight = 7'd25;
  localparam logic [CharW-1:0]      NewlineCode = 8'd10;
  localparam logic [CharW-1:0]      SpaceCode   = 8'd32;
  localparam logic [OrderW-1:0]     ClearedOrder = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BEGIN = 2'd1,
    OP_CHAR  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_WRITTEN = 3'd0,
    ST_OFF     = 3'd1,
    ST_HIDDEN  = 3'd2,
    ST_NEWLINE = 3'd3,
    ST_DONE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_FETCH,
    S_LOOKUP,
    S_WRITE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CharW-1:0]  ch_code;
    logic [AttrW-1:0]  attr;
    logic [OrderW-1:0] prio;
  } cell_t;

  localparam cell_t BlankCell = '{ch_code: SpaceCode, attr: '0, prio: ClearedOrder};

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic rd_en;
    logic cell_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

[sv/tcpc_ctrl.sv]
module tcpc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [1:0]                        opcode_i,
  input  logic [tcpc_pkg::CharW-1:0]        char_code_i,
  input  tcpc_pkg::sts_t                    sts_i,
  output tcpc_pkg::cmd_t                    cmd_o,
  output logic                              busy_o,
  output logic                              done_o
);

  tcpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcpc_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcpc_pkg::S_INIT: begin
        if (sts_i.clr_last) state_d = tcpc_pkg::S_IDLE;
      end
      tcpc_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (tcpc_pkg::op_e'(opcode_i))
            tcpc_pkg::OP_CLEAR: state_d = tcpc_pkg::S_CLEAR;
            tcpc_pkg::OP_BEGIN: state_d = tcpc_pkg::S_RESP;
            tcpc_pkg::OP_CHAR: begin
              state_d = (char_code_i == tcpc_pkg::NewlineCode) ? tcpc_pkg::S_RESP
                                                                : tcpc_pkg::S_FETCH;
            end
            tcpc_pkg::OP_READ:  state_d = tcpc_pkg::S_LOOKUP;
            default:            state_d = tcpc_pkg::S_IDLE;
          endcase
        end
      end
      tcpc_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = tcpc_pkg::S_RESP;
      end
      tcpc_pkg::S_FETCH:  state_d = tcpc_pkg::S_WRITE;
      tcpc_pkg::S_LOOKUP: state_d = tcpc_pkg::S_RESP;
      tcpc_pkg::S_WRITE:  state_d = tcpc_pkg::S_RESP;
      tcpc_pkg::S_RESP:   state_d = tcpc_pkg::S_IDLE;
      default:            state_d = tcpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == tcpc_pkg::S_IDLE) && start_i;
    cmd_o.clr_step = (state_q == tcpc_pkg::S_INIT) || (state_q == tcpc_pkg::S_CLEAR);
    cmd_o.rd_en    = (state_q == tcpc_pkg::S_FETCH) || (state_q == tcpc_pkg::S_LOOKUP);
    cmd_o.cell_wr  = (state_q == tcpc_pkg::S_WRITE);
    busy_o         = (state_q != tcpc_pkg::S_IDLE);
    done_o         = (state_q == tcpc_pkg::S_RESP);
  end

  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // a clear walk always ends in a result
  a_clear_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcpc_pkg::S_CLEAR && sts_i.clr_last) |=> done_o)
    else $error("clear walk finished without a result");

  // a cell update is always preceded by its fetch
  a_write_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cell_wr |-> $past(cmd_o.rd_en))
    else $error("cell update without a preceding fetch");

endmodule

[sv/tcpc_dp.sv]
module tcpc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcpc_pkg::cmd_t                    cmd_i,
  output tcpc_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [tcpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tcpc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [1:0]                        opcode_i,
  input  logic signed [tcpc_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [tcpc_pkg::CoordW-1:0] origin_y_i,
  input  logic [tcpc_pkg::AttrW-1:0]        text_color_i,
  input  logic signed [tcpc_pkg::OrderW-1:0] draw_order_i,
  input  logic [tcpc_pkg::CharW-1:0]        char_code_i,
  input  logic [tcpc_pkg::CellIndexW-1:0]   cell_index_i,
  output logic [tcpc_pkg::StatusW-1:0]      status_o,
  output logic [tcpc_pkg::CharW-1:0]        cell_char_o,
  output logic [tcpc_pkg::AttrW-1:0]        cell_attr_o,
  output logic signed [tcpc_pkg::OrderW-1:0] cell_order_o
);

  localparam int unsigned ProdW = tcpc_pkg::RowW + tcpc_pkg::WidthW + 1;
  localparam int unsigned AreaW = tcpc_pkg::WidthW + tcpc_pkg::HeightW;
  localparam int unsigned PosW  = tcpc_pkg::CoordW + 2;

  tcpc_pkg::cell_t mem_q [tcpc_pkg::CellCount];
  tcpc_pkg::cell_t rdata_q;

  logic [tcpc_pkg::ScrWidthW-1:0]  scr_w_q;
  logic [tcpc_pkg::ScrHeightW-1:0] scr_h_q;
  logic [tcpc_pkg::CoordW-1:0]     org_x_q, org_y_q;
  logic [tcpc_pkg::AttrW-1:0]      attr_q;
  logic [tcpc_pkg::OrderW-1:0]     order_q;
  logic [tcpc_pkg::CoordW-1:0]     col_q, row_q;
  logic [tcpc_pkg::CellIdxW-1:0]   clr_cnt_q, clr_last_q;

  logic [tcpc_pkg::CellIdxW-1:0]   addr_q;
  logic [tcpc_pkg::CharW-1:0]      char_q;
  logic                            off_q;
  logic                            rd_ok_q;
  tcpc_pkg::status_e               status_q;

  logic [tcpc_pkg::WidthW-1:0]     w_eff;
  logic [tcpc_pkg::HeightW-1:0]    h_eff;
  logic [AreaW-1:0]                area;
  logic signed [PosW-1:0]          x_s, y_s;
  logic [ProdW-1:0]                lin;
  logic                            off_c;
  logic                            read_ok_c;
  logic                            hidden;
  logic                            mem_we;
  logic [tcpc_pkg::CellIdxW-1:0]   waddr;
  tcpc_pkg::cell_t                 wdata;

  // effective screen size, zero means one and oversize means the maximum
  always_comb begin
    if (scr_w_q == '0) begin
      w_eff = tcpc_pkg::WidthW'(1);
    end else if (32'(scr_w_q) > tcpc_pkg::MaxColumns) begin
      w_eff = tcpc_pkg::WidthW'(tcpc_pkg::MaxColumns);
    end else begin
      w_eff = tcpc_pkg::WidthW'(scr_w_q);
    end
    if (scr_h_q == '0) begin
      h_eff = tcpc_pkg::HeightW'(1);
    end else if (32'(scr_h_q) > tcpc_pkg::MaxRows) begin
      h_eff = tcpc_pkg::HeightW'(tcpc_pkg::MaxRows);
    end else begin
      h_eff = tcpc_pkg::HeightW'(scr_h_q);
    end
  end

  assign area = AreaW'(w_eff) * AreaW'(h_eff);

  // cell position of the next character
  assign x_s = $signed({{2{org_x_q[tcpc_pkg::CoordW-1]}}, org_x_q}) + $signed({2'b00, col_q});
  assign y_s = $signed({{2{org_y_q[tcpc_pkg::CoordW-1]}}, org_y_q}) + $signed({2'b00, row_q});
  assign lin = ProdW'(y_s[tcpc_pkg::RowW-1:0]) * ProdW'(w_eff)
             + ProdW'(x_s[tcpc_pkg::ColW-1:0]);

  assign off_c = (x_s < 0) || (x_s >= $signed(PosW'(w_eff)))
              || (y_s < 0) || (y_s >= $signed(PosW'(h_eff)))
              || (32'(lin) >= tcpc_pkg::CellCount);

  assign read_ok_c = (32'(cell_index_i) < tcpc_pkg::CellCount);

  assign hidden = $signed(rdata_q.prio) > $signed(order_q);

  assign sts_o.clr_last = (clr_cnt_q == clr_last_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q    <= tcpc_pkg::ResetWidth;
      scr_h_q    <= tcpc_pkg::ResetHeight;
      org_x_q    <= '0;
      org_y_q    <= '0;
      attr_q     <= '0;
      order_q    <= '0;
      col_q      <= '0;
      row_q      <= '0;
      clr_cnt_q  <= '0;
      clr_last_q <= tcpc_pkg::CellIdxW'(tcpc_pkg::CellCount - 1);
    end else begin
      if (cfg_we_i) begin
        unique case (tcpc_pkg::reg_idx_e'(cfg_idx_i))
          tcpc_pkg::REG_WIDTH:  scr_w_q <= cfg_data_i[tcpc_pkg::ScrWidthW-1:0];
          tcpc_pkg::REG_HEIGHT: scr_h_q <= cfg_data_i[tcpc_pkg::ScrHeightW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= sts_o.clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        unique case (tcpc_pkg::op_e'(opcode_i))
          tcpc_pkg::OP_CLEAR: begin
            clr_cnt_q  <= '0;
            clr_last_q <= tcpc_pkg::CellIdxW'(area - AreaW'(1));
          end
          tcpc_pkg::OP_BEGIN: begin
            org_x_q <= origin_x_i;
            org_y_q <= origin_y_i;
            attr_q  <= text_color_i;
            order_q <= draw_order_i;
            col_q   <= '0;
            row_q   <= '0;
          end
          tcpc_pkg::OP_CHAR: begin
            if (char_code_i == tcpc_pkg::NewlineCode) begin
              row_q <= (row_q == '1) ? row_q : row_q + 1'b1;
              col_q <= '0;
            end else begin
              col_q <= (col_q == '1) ? col_q : col_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= char_code_i;
      off_q  <= off_c;
      unique case (tcpc_pkg::op_e'(opcode_i))
        tcpc_pkg::OP_CHAR: begin
          rd_ok_q <= 1'b0;
          addr_q  <= lin[tcpc_pkg::CellIdxW-1:0];
          if (char_code_i == tcpc_pkg::NewlineCode) status_q <= tcpc_pkg::ST_NEWLINE;
          else                                      status_q <= tcpc_pkg::ST_DONE;
        end
        tcpc_pkg::OP_READ: begin
          rd_ok_q <= read_ok_c;
          addr_q  <= tcpc_pkg::CellIdxW'(cell_index_i);
          if (read_ok_c) status_q <= tcpc_pkg::ST_DONE;
          else           status_q <= tcpc_pkg::ST_OFF;
        end
        default: begin
          rd_ok_q  <= 1'b0;
          addr_q   <= lin[tcpc_pkg::CellIdxW-1:0];
          status_q <= tcpc_pkg::ST_DONE;
        end
      endcase
    end else if (cmd_i.cell_wr) begin
      priority if (off_q) status_q <= tcpc_pkg::ST_OFF;
      else if (hidden)    status_q <= tcpc_pkg::ST_HIDDEN;
      else                status_q <= tcpc_pkg::ST_WRITTEN;
    end
  end

  // cell store: one write port shared by the clear walk and text writes
  assign mem_we = cmd_i.clr_step || (cmd_i.cell_wr && !off_q && !hidden);
  assign waddr  = cmd_i.clr_step ? clr_cnt_q : addr_q;
  assign wdata  = cmd_i.clr_step ? tcpc_pkg::BlankCell
                                 : tcpc_pkg::cell_t'{ch_code: char_q, attr: attr_q,
                                                     prio: order_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem_q[addr_q];
  end

  assign status_o     = status_q;
  assign cell_char_o  = rd_ok_q ? rdata_q.ch_code : '0;
  assign cell_attr_o  = rd_ok_q ? rdata_q.attr : '0;
  assign cell_order_o = rd_ok_q ? $signed(rdata_q.prio) : '0;

  // the clear walk and a text write never share the write port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && cmd_i.cell_wr))
    else $error("clear walk and cell update collide");

  // the walk counter never runs past its last cell
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> (clr_cnt_q <= clr_last_q))
    else $error("clear walk beyond its last cell");

  // an off-screen character leaves the store untouched
  a_off_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cell_wr && off_q) |-> !mem_we)
    else $error("off-screen character written");

endmodule

[sv/text_cell_priority_compositor.sv]
// Character-cell frame store with a draw priority kept in every cell.
// Command channel: an item is taken at a clock edge with start_i high and
// busy_o low; opcode_i picks clear, begin text, character or read cell.
// Result channel: done_o is high for exactly one cycle with status_o and the
// cell fields; the receiver cannot hold it off, so it must take every beat.
// Configuration: cfg_we_i writes screen width (index 0) or height (index 1)
// at once; write only while busy_o is low.
// Work between accept and result strobe, with busy_o high until it has passed:
//   begin text, newline: nothing beyond the latch update at accept
//   read cell: one registered read of the cell store
//   character: read, priority compare and conditional write of its cell
//   clear: every cell of the width-by-height area, one cell written per cycle
// An item can be taken in the cycle after its predecessor's strobe.
// After reset all 8192 cells of the store are walked once, one cell a cycle, to
// space, attribute 0 and priority -1; busy_o stays high until that is done.
// Cursor and text latches reset to zero, width to 80 and height to 25.
module text_cell_priority_compositor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [tcpc_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [tcpc_pkg::CoordW-1:0] origin_y_i,
  input  logic [tcpc_pkg::AttrW-1:0]        text_color_i,
  input  logic signed [tcpc_pkg::OrderW-1:0] draw_order_i,
  input  logic [tcpc_pkg::CharW-1:0]        char_code_i,
  input  logic [tcpc_pkg::CellIndexW-1:0]   cell_index_i,
  input  logic                              cfg_we_i,
  input  logic [tcpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tcpc_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                              done_o,
  output logic [tcpc_pkg::StatusW-1:0]      status_o,
  output logic [tcpc_pkg::CharW-1:0]        cell_char_o,
  output logic [tcpc_pkg::AttrW-1:0]        cell_attr_o,
  output logic signed [tcpc_pkg::OrderW-1:0] cell_order_o
);

  tcpc_pkg::cmd_t cmd;
  tcpc_pkg::sts_t sts;

  tcpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  tcpc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .text_color_i (text_color_i),
    .draw_order_i (draw_order_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .status_o     (status_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o),
    .cell_order_o (cell_order_o)
  );

endmodule
